FILE: rtl/osrmm_pkg.sv
// ----------------------------------------------------------------------------
// osrmm_pkg
// Shared types and constants for the overwriting sample ring with min/max.
// ----------------------------------------------------------------------------
package osrmm_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned LEN_W         = 11;
   localparam int unsigned SAMPLE_W      = 16;
   localparam int unsigned ENTRIES_W     = 10;

   localparam logic [LEN_W-1:0]           LEN_RESET  = 11'd1024;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO = 16'sd0;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                      cmd;
      logic signed [SAMPLE_W-1:0]   sample_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]   sample_out;
      logic                         read_ok;
      logic [ENTRIES_W-1:0]         entries_held;
      logic                         is_empty;
      logic                         is_full;
      logic signed [SAMPLE_W-1:0]   running_min;
      logic signed [SAMPLE_W-1:0]   running_max;
   } rsp_type;

   // status of one request, everything but the read sample
   typedef struct packed {
      logic                         read_ok;
      logic [ENTRIES_W-1:0]         entries_held;
      logic                         is_empty;
      logic                         is_full;
      logic signed [SAMPLE_W-1:0]   running_min;
      logic signed [SAMPLE_W-1:0]   running_max;
   } stat_type;

endpackage

FILE: rtl/osrmm_ram.sv
// ----------------------------------------------------------------------------
// osrmm_ram
// Sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module osrmm_ram #(
   parameter int unsigned DEPTH = osrmm_pkg::DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [AW-1:0]                          wr_addr,
   input  logic signed [osrmm_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                                   rd_en,
   input  logic [AW-1:0]                          rd_addr,
   output logic signed [osrmm_pkg::SAMPLE_W-1:0]  rd_data
);
   import osrmm_pkg::*;

   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/osrmm_ctrl.sv
// ----------------------------------------------------------------------------
// osrmm_ctrl
// Ring pointers, length register and running min/max; per-request status.
// ----------------------------------------------------------------------------
module osrmm_ctrl #(
   parameter int unsigned DEPTH = osrmm_pkg::DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [osrmm_pkg::LEN_W-1:0]            csr_write_data,
   input  logic                                   accept,
   input  osrmm_pkg::req_type                     req,
   output logic                                   wr_en,
   output logic [AW-1:0]                          wr_addr,
   output logic signed [osrmm_pkg::SAMPLE_W-1:0]  wr_data,
   output logic                                   rd_en,
   output logic [AW-1:0]                          rd_addr,
   output osrmm_pkg::stat_type                    stat
);
   import osrmm_pkg::*;

   localparam int unsigned DW = $clog2(DEPTH + 1);
   localparam int unsigned CW = (DW > LEN_W) ? DW : LEN_W;

   logic [LEN_W-1:0]           length_ff;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [AW-1:0]              rp_ff, rp_in;
   logic signed [SAMPLE_W-1:0] low_ff, low_in;
   logic signed [SAMPLE_W-1:0] high_ff, high_in;

   logic [CW-1:0] len_c;
   logic [CW-1:0] len_raw;
   logic [CW-1:0] wp_plus, rp_plus, wpn_plus;
   logic [AW-1:0] wp_ring, rp_ring, wpn_ring;
   logic [CW-1:0] diff;
   logic          is_write;
   logic          ok;

   always_comb begin
      len_raw = CW'(length_ff);
      if (len_raw < CW'(2)) begin
         len_c = CW'(2);
      end else if (len_raw > CW'(DEPTH)) begin
         len_c = CW'(DEPTH);
      end else begin
         len_c = len_raw;
      end
   end

   always_comb begin
      wp_plus = CW'(wp_ff) + CW'(1);
      rp_plus = CW'(rp_ff) + CW'(1);
      wp_ring = (wp_plus == len_c) ? '0 : wp_plus[AW-1:0];
      rp_ring = (rp_plus == len_c) ? '0 : rp_plus[AW-1:0];
      is_write = (req.cmd == CMD_WRITE);
      ok       = 1'b0;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (is_write) begin
         wp_in = wp_ring;
         if (wp_ring == rp_ff) begin
            rp_in = rp_ring;
         end
         if (req.sample_in < low_ff) begin
            low_in = req.sample_in;
         end
         if (req.sample_in > high_ff) begin
            high_in = req.sample_in;
         end
      end else if (rp_ff != wp_ff) begin
         ok    = 1'b1;
         rp_in = rp_ring;
      end
   end

   // status after this request
   always_comb begin
      wpn_plus = CW'(wp_in) + CW'(1);
      wpn_ring = (wpn_plus == len_c) ? '0 : wpn_plus[AW-1:0];
      if (wp_in >= rp_in) begin
         diff = CW'(wp_in) - CW'(rp_in);
      end else begin
         diff = CW'(wp_in) + len_c - CW'(rp_in);
      end
      stat.read_ok      = ok;
      stat.entries_held = diff[ENTRIES_W-1:0];
      stat.is_empty     = (wp_in == rp_in);
      stat.is_full      = (wpn_ring == rp_in);
      stat.running_min  = low_in;
      stat.running_max  = high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_RESET;
         wp_ff     <= '0;
         rp_ff     <= '0;
         low_ff    <= SAMPLE_MAX;
         high_ff   <= SAMPLE_ZERO;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
         wp_ff     <= '0;
         rp_ff     <= '0;
      end else if (accept) begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign wr_en   = accept & is_write;
   assign wr_addr = wp_ff;
   assign wr_data = req.sample_in;
   assign rd_en   = accept & ~is_write;
   assign rd_addr = rp_ff;

endmodule

FILE: rtl/osrmm_out.sv
// ----------------------------------------------------------------------------
// osrmm_out
// Status stage aligned with the RAM read, then the response register.
// ----------------------------------------------------------------------------
module osrmm_out (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  osrmm_pkg::stat_type                    stat,
   input  logic signed [osrmm_pkg::SAMPLE_W-1:0]  rd_data,
   output logic                                   req_stall,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output osrmm_pkg::rsp_type                     rsp_data
);
   import osrmm_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   stat_type s1_stat_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff, out_data_in;
   logic     s1_move;

   assign s1_move   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;

   always_comb begin
      s1_valid_in  = accept | (s1_valid_ff & ~s1_move);
      out_valid_in = s1_move | (out_valid_ff & rsp_stall);
      out_data_in.sample_out   = s1_stat_ff.read_ok ? rd_data : SAMPLE_ZERO;
      out_data_in.read_ok      = s1_stat_ff.read_ok;
      out_data_in.entries_held = s1_stat_ff.entries_held;
      out_data_in.is_empty     = s1_stat_ff.is_empty;
      out_data_in.is_full      = s1_stat_ff.is_full;
      out_data_in.running_min  = s1_stat_ff.running_min;
      out_data_in.running_max  = s1_stat_ff.running_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= stat;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: rtl/overwriting_sample_ring_with_min_max_core.sv
// ----------------------------------------------------------------------------
// overwriting_sample_ring_with_min_max_core
// Overwriting ring of Q1.15 samples with running minimum and maximum.
// ----------------------------------------------------------------------------
// Response: registered in the status stage (with the RAM read), then in the response register.
// Throughput: one request per cycle while req_stall is low; the single RAM port
//   pair and the pointer update do not stall it.
// Reset (synchronous): pointers to zero, length 1024, min 32767, max 0.
//   The sample store is not cleared.
module overwriting_sample_ring_with_min_max_core #(
   parameter int unsigned DEPTH = osrmm_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  osrmm_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output osrmm_pkg::rsp_type            rsp_data,
   input  logic                          csr_write_enable,
   input  logic [osrmm_pkg::LEN_W-1:0]   csr_write_data
);
   import osrmm_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic                       accept;
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic signed [SAMPLE_W-1:0] wr_data, rd_data;
   stat_type                   stat;

   assign accept = req_valid & ~req_stall;

   osrmm_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req              (req_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .stat             (stat)
   );

   osrmm_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   osrmm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .stat      (stat),
      .rd_data   (rd_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.entries_held == '0)
      else $error("empty ring reports entries");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("ring both empty and full");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.read_ok |-> rsp_data.sample_out == SAMPLE_ZERO)
      else $error("sample on failed read or write");

   a_max_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.running_max[SAMPLE_W-1])
      else $error("running max below zero");

endmodule
